// ----- hw/rtl/leap_second_time_convert_macros.svh -----
// Assertion macros shared by the leap-second converter RTL
`ifndef LEAP_SECOND_TIME_CONVERT_MACROS_SVH
`define LEAP_SECOND_TIME_CONVERT_MACROS_SVH

// checked on every clock edge outside reset
`define LSTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define LSTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hw/rtl/lstc_pkg.sv -----
// Types and constants of the leap-second time converter
`default_nettype none

package lstc_pkg;

  localparam int TIME_W  = 50;
  localparam int KEY_W   = 34;
  localparam int OFF_W   = 8;
  localparam int NTP_W   = 33;
  localparam int EXP_W   = 33;
  localparam int OP_W    = 3;
  localparam int ERR_W   = 2;
  // bits needed for the positive epoch constants in whole seconds
  localparam int EPOCH_W = 30;

  localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 3'd1;
  localparam logic [OP_W-1:0] OP_M2UTC = 3'd2;
  localparam logic [OP_W-1:0] OP_UTC2M = 3'd3;
  localparam logic [OP_W-1:0] OP_M2TAI = 3'd4;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd3;

  localparam longint NTP_TO_UNIX = 64'sd2208988800;
  localparam longint EPOCH_UNIX  = 64'sd946728000;
  localparam longint EPOCH_TAI   = 64'sd946728032;

  // one table row
  typedef struct packed {
    logic signed [KEY_W-1:0] unix_sec;
    logic signed [KEY_W-1:0] tai_sec;
    logic signed [OFF_W-1:0] offset;
  } entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/leap_second_time_convert.sv -----
// Leap-second table with mission time, UTC and TAI conversion
//
//  channel   direction  handshake                  payload
//  command   in         start & !busy              operation, time_value, ntp_seconds,
//                                                  tai_minus_utc
//  result    out        done_o, one cycle          result_time, error_code, table_stale
//  config    in         expiration_unix_we_i       expiration_unix
//
// Clear, load, mission to TAI and errors need no table search. Conversions read
// the last row first and finish when it matches, else check row zero and bisect
// the table; the table RAM gives one probe per cycle through its registered read.
// The result word shows on done_o in the cycle busy falls; a new word may be
// started in that same cycle. The receiver cannot stall.
// Reset empties the table and sets the expiration to all ones; no clearing pass.
`default_nettype none
`include "leap_second_time_convert_macros.svh"

module leap_second_time_convert #(
  parameter int TABLE_DEPTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [lstc_pkg::OP_W-1:0]            operation_i,
  input  logic signed [lstc_pkg::TIME_W-1:0]   time_value_i,
  input  logic [lstc_pkg::NTP_W-1:0]           ntp_seconds_i,
  input  logic signed [lstc_pkg::OFF_W-1:0]    tai_minus_utc_i,
  input  logic                                 expiration_unix_we_i,
  input  logic [lstc_pkg::EXP_W-1:0]           expiration_unix_i,
  output logic                                 done_o,
  output logic signed [lstc_pkg::TIME_W-1:0]   result_time_o,
  output logic [lstc_pkg::ERR_W-1:0]           error_code_o,
  output logic                                 table_stale_o
);

  import lstc_pkg::*;

  localparam int AddrW = $clog2(TABLE_DEPTH);
  localparam int CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int AccW  = ((TIME_W > EPOCH_W + FRAC_BITS) ? TIME_W : EPOCH_W + FRAC_BITS) + 2;
  localparam int CmpW  = ((AccW > KEY_W) ? AccW : KEY_W) + 1;
  localparam int EntW  = $bits(entry_t);

  localparam logic signed [AccW-1:0] EpochTaiFx  = AccW'(EPOCH_TAI * (longint'(1) << FRAC_BITS));
  localparam logic signed [AccW-1:0] EpochUnixFx = AccW'(EPOCH_UNIX * (longint'(1) << FRAC_BITS));
  localparam logic signed [AccW-1:0] NtpToUnix   = AccW'(NTP_TO_UNIX);
  localparam logic signed [AccW-1:0] TimeMax     = AccW'((longint'(1) << (TIME_W - 1)) - 1);
  localparam logic signed [AccW-1:0] TimeMin     = AccW'(-(longint'(1) << (TIME_W - 1)));

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_KEY   = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_LAST  = 3'd3;
  localparam logic [2:0] ST_FIRST = 3'd4;
  localparam logic [2:0] ST_BIS   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]              state_q, state_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [EXP_W-1:0]        exp_q;
  logic [ERR_W-1:0]        err_q, err_d;
  logic                    done_q, done_d;

  logic [OP_W-1:0]         op_q, op_d;
  logic signed [TIME_W-1:0] t_q, t_d;
  logic [NTP_W-1:0]        ntp_q, ntp_d;
  logic signed [OFF_W-1:0] tmu_q, tmu_d;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic signed [OFF_W-1:0] off_q, off_d;
  logic [CntW-1:0]         lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic signed [TIME_W-1:0] result_q, result_d;
  logic [ERR_W-1:0]        code_q, code_d;
  logic                    stale_q, stale_d;

  // shared add/subtract unit
  logic signed [AccW-1:0]  add_a, add_b, add_sum;
  logic                    add_sub;

  // shared compare unit
  logic signed [AccW-1:0]  cmp_key;
  logic signed [AccW-1:0]  cmp_int;
  logic signed [KEY_W-1:0] ent_key;
  logic signed [CmpW-1:0]  cmp_b;
  logic                    ge;

  logic                    ram_we;
  logic [AddrW-1:0]        ram_waddr, ram_raddr;
  logic [EntW-1:0]         ram_rdata;
  entry_t                  ram_wentry, rd;

  logic [CntW-1:0]         cnt_m1, lo_n, hi_n, mid_n;
  logic [CntW:0]           span_sum;
  logic                    probe_more;
  logic                    rng_err;
  logic signed [AccW-1:0]  off_fx;

  assign busy          = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign result_time_o = result_q;
  assign error_code_o  = code_q;
  assign table_stale_o = stale_q;

  lstc_ram #(
    .Width (EntW),
    .Depth (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wentry),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd = ram_rdata;

  assign off_fx  = AccW'(off_q) <<< FRAC_BITS;
  assign add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);

  always_comb begin
    add_a   = AccW'(t_q);
    add_b   = EpochTaiFx;
    add_sub = 1'b0;
    case (state_q)
      ST_KEY: begin
        if (op_q == OP_LOAD) begin
          add_a   = AccW'($signed({1'b0, ntp_q}));
          add_b   = NtpToUnix;
          add_sub = 1'b1;
        end else if (op_q == OP_UTC2M) begin
          add_sub = 1'b1;
        end
      end
      ST_LOAD: begin
        add_a = acc_q;
        add_b = AccW'(tmu_q);
      end
      ST_FIN: begin
        add_a   = acc_q;
        add_b   = off_fx;
        add_sub = (op_q == OP_M2UTC);
      end
      default: ;
    endcase
  end

  // search key: TAI for mission to UTC, else UTC; in DONE the same mux gives the UTC
  assign cmp_key = (op_q == OP_M2UTC) ? acc_q : AccW'(t_q);
  assign cmp_int = cmp_key >>> FRAC_BITS;
  assign ent_key = (op_q == OP_M2UTC) ? rd.tai_sec : rd.unix_sec;
  assign cmp_b   = (state_q == ST_DONE) ? CmpW'($signed({1'b0, exp_q})) : CmpW'(ent_key);
  assign ge      = (CmpW'(cmp_int) >= cmp_b);

  assign rng_err = (op_q == OP_M2UTC) ? t_q[TIME_W-1] : (AccW'(t_q) < EpochUnixFx);

  // bisection bounds after the current probe
  always_comb begin
    if (state_q == ST_FIRST) begin
      lo_n = '0;
      hi_n = cnt_q;
    end else if (ge) begin
      lo_n = mid_q;
      hi_n = hi_q;
    end else begin
      lo_n = lo_q;
      hi_n = mid_q;
    end
    span_sum   = {1'b0, lo_n} + {1'b0, hi_n};
    mid_n      = span_sum[CntW:1];
    probe_more = (({1'b0, lo_n} + (CntW + 1)'(1)) < {1'b0, hi_n});
  end

  assign cnt_m1 = cnt_q - CntW'(1);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    err_d      = err_q;
    done_d     = 1'b0;
    op_d       = op_q;
    t_d        = t_q;
    ntp_d      = ntp_q;
    tmu_d      = tmu_q;
    acc_d      = acc_q;
    off_d      = off_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    mid_d      = mid_q;
    result_d   = result_q;
    code_d     = code_q;
    stale_d    = stale_q;
    ram_we     = 1'b0;
    ram_waddr  = cnt_q[AddrW-1:0];
    ram_raddr  = '0;
    ram_wentry.unix_sec = acc_q[KEY_W-1:0];
    ram_wentry.tai_sec  = add_sum[KEY_W-1:0];
    ram_wentry.offset   = tmu_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          op_d    = operation_i;
          t_d     = time_value_i;
          ntp_d   = ntp_seconds_i;
          tmu_d   = tai_minus_utc_i;
          err_d   = ERR_OK;
          state_d = ST_KEY;
        end
      end
      ST_KEY: begin
        acc_d = add_sum;
        unique case (op_q) inside
          OP_CLEAR: begin
            cnt_d   = '0;
            state_d = ST_DONE;
          end
          OP_LOAD: begin
            if (cnt_q == CntW'(TABLE_DEPTH)) begin
              err_d   = ERR_FULL;
              state_d = ST_DONE;
            end else begin
              state_d = ST_LOAD;
            end
          end
          OP_M2UTC, OP_UTC2M: begin
            if (rng_err) begin
              err_d   = ERR_RANGE;
              state_d = ST_DONE;
            end else if (cnt_q == '0) begin
              err_d   = ERR_EMPTY;
              state_d = ST_DONE;
            end else begin
              ram_raddr = cnt_m1[AddrW-1:0];
              state_d   = ST_LAST;
            end
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_LOAD: begin
        ram_we  = 1'b1;
        cnt_d   = cnt_q + CntW'(1);
        state_d = ST_DONE;
      end
      ST_LAST: begin
        if (ge) begin
          off_d   = rd.offset;
          state_d = ST_FIN;
        end else begin
          state_d = ST_FIRST;
        end
      end
      ST_FIRST: begin
        if (!ge) begin
          off_d   = '0;
          state_d = ST_FIN;
        end else begin
          off_d = rd.offset;
          lo_d  = lo_n;
          hi_d  = hi_n;
          if (probe_more) begin
            mid_d     = mid_n;
            ram_raddr = mid_n[AddrW-1:0];
            state_d   = ST_BIS;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_BIS: begin
        if (ge) begin
          off_d = rd.offset;
        end
        lo_d = lo_n;
        hi_d = hi_n;
        if (probe_more) begin
          mid_d     = mid_n;
          ram_raddr = mid_n[AddrW-1:0];
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        acc_d   = add_sum;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        done_d   = 1'b1;
        code_d   = err_q;
        result_d = '0;
        stale_d  = 1'b0;
        if (err_q == ERR_OK &&
            (op_q == OP_M2UTC || op_q == OP_UTC2M || op_q == OP_M2TAI)) begin
          if (acc_q > TimeMax) begin
            result_d = TimeMax[TIME_W-1:0];
          end else if (acc_q < TimeMin) begin
            result_d = TimeMin[TIME_W-1:0];
          end else begin
            result_d = acc_q[TIME_W-1:0];
          end
          stale_d = (op_q != OP_M2TAI) && ge;
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      exp_q   <= '1;
      err_q   <= ERR_OK;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
      done_q  <= done_d;
      if (expiration_unix_we_i) begin
        exp_q <= expiration_unix_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    t_q      <= t_d;
    ntp_q    <= ntp_d;
    tmu_q    <= tmu_d;
    acc_q    <= acc_d;
    off_q    <= off_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    result_q <= result_d;
    code_q   <= code_d;
    stale_q  <= stale_d;
  end

  `LSTC_ASSERT(a_done_when_idle, done_q |-> (state_q == ST_IDLE), "result word while busy")
  `LSTC_ASSERT(a_done_single, done_q |=> !done_q, "result strobe longer than one cycle")
  `LSTC_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
  `LSTC_ASSERT(a_err_zero, (done_q && code_q != ERR_OK) |-> (result_q == '0 && !stale_q), "error word carries a value")
  `LSTC_ASSERT(a_cnt_bound, cnt_q <= CntW'(TABLE_DEPTH), "table count beyond depth")
  `LSTC_ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> (cnt_q == '0 && !done_q), "table not empty in reset")

endmodule

`default_nettype wire

// ----- hw/rtl/lstc_ram.sv -----
// Generic simple dual-port RAM with registered read
`default_nettype none

module lstc_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire
